// ===== rtl/neuron_mac_relu_defines.svh =====
// Assertion macros shared by the neuron MAC block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef NEURON_MAC_RELU_DEFINES_SVH
`define NEURON_MAC_RELU_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nmr_pkg.sv =====
// Shared types and constants for the neuron MAC / ReLU block.
// No dependencies.
package nmr_pkg;

	// supported range 1..64 (link_index is 6 bits wide)
	localparam int LINK_COUNT = 64;
	localparam int LINK_AW    = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SUM_W  = 48;
	localparam int FRAC_SHIFT = 12;

	// result queue, deep enough to hide the pipeline
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_SAMPLE   = 2'd0,
		ACT_SET_W    = 2'd1,
		ACT_ADD_W    = 2'd2,
		ACT_ADD_BIAS = 2'd3
	} action_t;

endpackage

// ===== rtl/neuron_mac_relu.sv =====
// Last samples pass the pipeline stages and the queue to m_axis. Throughput: one item per
// cycle unless stalled; one weight RAM read and one write per cycle, a one-entry forward
// covers a write to the link read just behind it. An 8-entry result queue absorbs output
// stalls; s_axis_tready drops once the queue plus results in flight reach 8.
// Reset clears weight valid bits (weights read as zero), bias, sum, mode, queue.
// Depends on nmr_pkg, nmr_ram and neuron_mac_relu_defines.svh.
`include "neuron_mac_relu_defines.svh"

module neuron_mac_relu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // neuron_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // action[1:0], link_index[7:2], value[23:8]
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata    // preactivation[47:0], activation[95:48]
);

	localparam int OUT_W = 2 * nmr_pkg::SUM_W;

	function automatic logic signed [nmr_pkg::VAL_W-1:0] sat16(
		input logic signed [nmr_pkg::VAL_W:0] s);
		if (s[nmr_pkg::VAL_W] != s[nmr_pkg::VAL_W-1]) begin
			return s[nmr_pkg::VAL_W] ? {1'b1, {(nmr_pkg::VAL_W-1){1'b0}}}
			                         : {1'b0, {(nmr_pkg::VAL_W-1){1'b1}}};
		end
		return s[nmr_pkg::VAL_W-1:0];
	endfunction

	function automatic logic signed [nmr_pkg::SUM_W-1:0] sat48(
		input logic signed [nmr_pkg::SUM_W:0] s);
		if (s[nmr_pkg::SUM_W] != s[nmr_pkg::SUM_W-1]) begin
			return s[nmr_pkg::SUM_W] ? {1'b1, {(nmr_pkg::SUM_W-1){1'b0}}}
			                         : {1'b0, {(nmr_pkg::SUM_W-1){1'b1}}};
		end
		return s[nmr_pkg::SUM_W-1:0];
	endfunction

	// input unpack
	nmr_pkg::action_t                  in_act;
	logic [5:0]                        in_link;
	logic signed [nmr_pkg::VAL_W-1:0]  in_val;
	logic                              in_acc;
	logic                              in_rng;
	logic [nmr_pkg::LINK_AW-1:0]       in_addr;

	assign in_act  = nmr_pkg::action_t'(s_axis_tdata[1:0]);
	assign in_link = s_axis_tdata[7:2];
	assign in_val  = s_axis_tdata[23:8];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_rng  = int'(in_link) < nmr_pkg::LINK_COUNT;
	assign in_addr = in_link[nmr_pkg::LINK_AW-1:0];

	logic mode_q;
	logic [nmr_pkg::LINK_COUNT-1:0] wvalid_q;

	// stage 1: weight read data arrives
	logic                              vld_s1, rng_s1, last_s1, wvld_s1;
	nmr_pkg::action_t                  act_s1;
	logic [nmr_pkg::LINK_AW-1:0]       addr_s1;
	logic signed [nmr_pkg::VAL_W-1:0]  val_s1;
	logic signed [nmr_pkg::VAL_W-1:0]  ram_rdata;

	// stage 2: accumulate, plus last weight write for forwarding
	logic                              vld_s2, rng_s2, last_s2;
	nmr_pkg::action_t                  act_s2;
	logic signed [nmr_pkg::VAL_W-1:0]  val_s2;
	logic signed [nmr_pkg::PROD_W-1:0] prod_s2;
	logic                              fwd_vld_s2;
	logic [nmr_pkg::LINK_AW-1:0]       fwd_addr_s2;
	logic signed [nmr_pkg::VAL_W-1:0]  fwd_data_s2;

	// stage 3: bias add and activation
	logic                              res_s3;
	logic signed [nmr_pkg::SUM_W-1:0]  sum_s3;
	logic signed [nmr_pkg::VAL_W-1:0]  bias_s3;

	logic signed [nmr_pkg::SUM_W-1:0]  acc_q;
	logic signed [nmr_pkg::VAL_W-1:0]  bias_q;

	// stage 1 weight resolve and update
	logic signed [nmr_pkg::VAL_W-1:0]  w_s1;
	logic signed [nmr_pkg::VAL_W-1:0]  wnew_s1;
	logic                              wr_en_s1;

	always_comb begin
		if (fwd_vld_s2 && fwd_addr_s2 == addr_s1) begin
			w_s1 = fwd_data_s2;
		end else if (wvld_s1) begin
			w_s1 = ram_rdata;
		end else begin
			w_s1 = '0;
		end
		wr_en_s1 = vld_s1 && rng_s1 &&
		           (act_s1 == nmr_pkg::ACT_SET_W || act_s1 == nmr_pkg::ACT_ADD_W);
		if (act_s1 == nmr_pkg::ACT_SET_W) begin
			wnew_s1 = val_s1;
		end else begin
			wnew_s1 = sat16({w_s1[nmr_pkg::VAL_W-1], w_s1} +
			                {val_s1[nmr_pkg::VAL_W-1], val_s1});
		end
	end

	nmr_ram #(
		.WIDTH (nmr_pkg::VAL_W),
		.DEPTH (nmr_pkg::LINK_COUNT)
	) u_wram (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (addr_s1),
		.wdata (wnew_s1),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// stage 2 accumulate
	logic signed [nmr_pkg::SUM_W-1:0] acc_next;
	logic                             mac_s2;

	assign mac_s2 = vld_s2 && act_s2 == nmr_pkg::ACT_SAMPLE;

	always_comb begin
		if (rng_s2) begin
			acc_next = sat48({acc_q[nmr_pkg::SUM_W-1], acc_q} +
			                 {{(nmr_pkg::SUM_W + 1 - nmr_pkg::PROD_W)
			                   {prod_s2[nmr_pkg::PROD_W-1]}}, prod_s2});
		end else begin
			acc_next = acc_q;
		end
	end

	// stage 3 bias and activation
	logic signed [nmr_pkg::SUM_W-1:0] pre_s3;
	logic signed [nmr_pkg::SUM_W-1:0] actv_s3;

	always_comb begin
		pre_s3 = sat48({sum_s3[nmr_pkg::SUM_W-1], sum_s3} +
		               {{(nmr_pkg::SUM_W + 1 - nmr_pkg::VAL_W - nmr_pkg::FRAC_SHIFT)
		                 {bias_s3[nmr_pkg::VAL_W-1]}}, bias_s3,
		                {nmr_pkg::FRAC_SHIFT{1'b0}}});
		if (!mode_q && pre_s3[nmr_pkg::SUM_W-1]) begin
			actv_s3 = '0;
		end else begin
			actv_s3 = pre_s3;
		end
	end

	// result queue
	logic [OUT_W-1:0]            fifo_q [nmr_pkg::FIFO_DEPTH];
	logic [nmr_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [nmr_pkg::FIFO_CW-1:0] cnt_q;
	logic                        pop;
	logic                        res_s1, res_s2;
	logic [1:0]                  pend;
	logic [nmr_pkg::FIFO_CW:0]   room_use;

	assign pop      = m_axis_tvalid && m_axis_tready;
	assign res_s1   = vld_s1 && act_s1 == nmr_pkg::ACT_SAMPLE && last_s1;
	assign res_s2   = mac_s2 && last_s2;
	assign pend     = 2'(res_s1) + 2'(res_s2) + 2'(res_s3);
	assign room_use = (nmr_pkg::FIFO_CW + 1)'(cnt_q) + (nmr_pkg::FIFO_CW + 1)'(pend);

	assign s_axis_tready = int'(room_use) < nmr_pkg::FIFO_DEPTH;
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		act_s1  <= in_act;
		addr_s1 <= in_addr;
		val_s1  <= in_val;
		last_s1 <= s_axis_tlast;
		rng_s1  <= in_rng;
		wvld_s1 <= wvalid_q[in_addr];

		act_s2  <= act_s1;
		val_s2  <= val_s1;
		last_s2 <= last_s1;
		rng_s2  <= rng_s1;
		prod_s2 <= (nmr_pkg::PROD_W)'(val_s1) * (nmr_pkg::PROD_W)'(w_s1);
		fwd_addr_s2 <= addr_s1;
		fwd_data_s2 <= wnew_s1;

		if (res_s2) begin
			sum_s3  <= acc_next;
			bias_s3 <= bias_q;
		end
		if (res_s3) begin
			fifo_q[wr_ptr_q] <= {actv_s3, pre_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			wvalid_q   <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			fwd_vld_s2 <= 1'b0;
			res_s3     <= 1'b0;
			acc_q      <= '0;
			bias_q     <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (wr_en_s1) begin
				wvalid_q[addr_s1] <= 1'b1;
			end
			vld_s1     <= in_acc;
			vld_s2     <= vld_s1;
			fwd_vld_s2 <= wr_en_s1;
			res_s3     <= res_s2;

			if (mac_s2) begin
				acc_q <= last_s2 ? '0 : acc_next;
			end
			if (vld_s2 && act_s2 == nmr_pkg::ACT_ADD_BIAS) begin
				bias_q <= sat16({bias_q[nmr_pkg::VAL_W-1], bias_q} +
				                {val_s2[nmr_pkg::VAL_W-1], val_s2});
			end

			if (res_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res_s3 && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!res_s3 && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`NMR_ASSERT_NOW(a_fifo_no_overflow, res_s3 && !pop, int'(cnt_q) < nmr_pkg::FIFO_DEPTH, "result queue overflow")
	`NMR_ASSERT_NOW(a_acc_cleared, res_s3, acc_q == '0, "sum not cleared after last sample")
	`NMR_ASSERT_NEXT(a_fwd_tracks_write, wr_en_s1, fwd_vld_s2 && wvalid_q[fwd_addr_s2], "weight write not forwarded")
	`NMR_ASSERT_NOW(a_relu_nonneg, m_axis_tvalid && !mode_q, !m_axis_tdata[OUT_W-1], "ReLU output negative")

endmodule

// ===== rtl/nmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for neuron_mac_relu: drives weight, bias and sample items
// with random idling on both streams and checks every result against a local predictor.
// Depends on nmr_pkg and the neuron_mac_relu RTL.
module tb;

	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;

	typedef struct {
		nmr_pkg::action_t   action;
		logic [5:0]         link;
		logic signed [15:0] value;
		logic               last;
	} neuron_item_t;

	typedef struct {
		logic [47:0] pre;
		logic [47:0] act;
	} neuron_result_t;

	// Tracks weights, bias and running sum; queues the expected result of each last sample.
	class neuron_scoreboard;
		logic signed [15:0] weights [nmr_pkg::LINK_COUNT];
		logic signed [15:0] bias;
		logic signed [47:0] running_sum;
		logic               mode;
		neuron_result_t     awaited[$];
		int                 items_seen;
		int                 results_seen;
		int                 failures;

		function new();
			foreach (weights[i]) weights[i] = '0;
			bias = '0;
			running_sum = '0;
			mode = 1'b0;
			items_seen = 0;
			results_seen = 0;
			failures = 0;
		endfunction

		static function logic signed [15:0] clamp16(longint v);
			if (v > 32767) return 16'sh7FFF;
			if (v < -32768) return 16'sh8000;
			return v[15:0];
		endfunction

		static function logic signed [47:0] clamp48(longint v);
			if (v > SUM_HI) return 48'sh7FFF_FFFF_FFFF;
			if (v < SUM_LO) return 48'sh8000_0000_0000;
			return v[47:0];
		endfunction

		function void note_input(neuron_item_t it);
			longint         pre;
			neuron_result_t res;
			bit             in_range;
			items_seen++;
			in_range = int'(it.link) < nmr_pkg::LINK_COUNT;
			case (it.action)
				nmr_pkg::ACT_SAMPLE: begin
					if (in_range)
						running_sum = clamp48(longint'(running_sum)
							+ longint'(it.value) * longint'(weights[it.link]));
					if (it.last) begin
						pre = clamp48(longint'(running_sum) + longint'(bias) * 4096);
						res.pre = pre[47:0];
						res.act = (!mode && pre < 0) ? 48'd0 : pre[47:0];
						running_sum = '0;
						awaited.insert(awaited.size(), res);
					end
				end
				nmr_pkg::ACT_SET_W: begin
					if (in_range) weights[it.link] = it.value;
				end
				nmr_pkg::ACT_ADD_W: begin
					if (in_range)
						weights[it.link] = clamp16(longint'(weights[it.link])
							+ longint'(it.value));
				end
				nmr_pkg::ACT_ADD_BIAS: begin
					bias = clamp16(longint'(bias) + longint'(it.value));
				end
			endcase
		endfunction

		function void check_result(logic [95:0] beat);
			neuron_result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: preactivation %0d", $signed(beat[47:0]));
				failures++;
				return;
			end
			want = awaited.pop_front();
			results_seen++;
			if (beat[47:0] !== want.pre) begin
				$error("preactivation: expected %0d, got %0d",
					$signed(want.pre), $signed(beat[47:0]));
				failures++;
			end
			if (beat[95:48] !== want.act) begin
				$error("activation: expected %0d, got %0d",
					$signed(want.act), $signed(beat[95:48]));
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // action[1:0], link_index[7:2], value[23:8]
	logic        s_axis_tlast;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;   // preactivation[47:0], activation[95:48]

	neuron_scoreboard sb;
	bit               steady = 1'b0;
	int               mode_writes = 0;

	neuron_mac_relu u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic bit stall_now();
		return !steady && ($urandom_range(0, 99) < 22);
	endfunction

	function automatic neuron_item_t make_item(nmr_pkg::action_t a, logic [5:0] link,
			logic signed [15:0] v, logic last);
		neuron_item_t it;
		it.action = a;
		it.link = link;
		it.value = v;
		it.last = last;
		return it;
	endfunction

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(input neuron_item_t it);
		while (stall_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.value, it.link, it.action};
		s_axis_tlast <= it.last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	// Wait for every pending result, then let weight/bias updates still in the pipe retire.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
		mode_writes++;
	endtask

	task automatic run_random(input int count);
		int           sent;
		int           pick;
		int           len;
		neuron_item_t it;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
					: $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'($urandom), rand_value(),
						k == len - 1));
				sent += len;
			end else begin
				if (pick < 82) it.action = nmr_pkg::ACT_SET_W;
				else if (pick < 92) it.action = nmr_pkg::ACT_ADD_W;
				else if (pick < 97) it.action = nmr_pkg::ACT_ADD_BIAS;
				else it.action = nmr_pkg::action_t'($urandom_range(0, 3));
				it.link = 6'($urandom);
				it.value = rand_value();
				it.last = 1'($urandom);
				send_item(it);
				sent++;
			end
		end
		// close any open sum so the next phase starts clean
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'($urandom), rand_value(), 1'b1));
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= !stall_now();
		end
	end

	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(1'b0);
		// zero weights give a zero sum; last is ignored on updates
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd0, 16'sh7FFF, 1'b1));
		send_item(make_item(nmr_pkg::ACT_SET_W, 6'd0, 16'sh7FFF, 1'b1));
		send_item(make_item(nmr_pkg::ACT_SET_W, 6'd63, 16'sh8000, 1'b0));
		send_item(make_item(nmr_pkg::ACT_ADD_W, 6'd0, 16'sd1, 1'b0));
		send_item(make_item(nmr_pkg::ACT_ADD_W, 6'd63, -16'sd1, 1'b1));
		send_item(make_item(nmr_pkg::ACT_ADD_BIAS, 6'd0, 16'sh7FFF, 1'b0));
		send_item(make_item(nmr_pkg::ACT_ADD_BIAS, 6'd17, 16'sh7FFF, 1'b1));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd0, 16'sh8000, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd63, 16'sh8000, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd63, 16'sh7FFF, 1'b1));
		send_item(make_item(nmr_pkg::ACT_ADD_BIAS, 6'd0, 16'sh8000, 1'b0));
		send_item(make_item(nmr_pkg::ACT_ADD_BIAS, 6'd0, 16'sh8000, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd1, 16'sh1234, 1'b1));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd0, 16'sh7FFF, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd0, 16'sh7FFF, 1'b1));
		settle();
		write_mode(1'b1);
		// identity lets negative sums through
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd1, 16'sd0, 1'b1));
		send_item(make_item(nmr_pkg::ACT_SET_W, 6'd62, 16'sh5555, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd62, 16'shAAAA, 1'b1));
		send_item(make_item(nmr_pkg::ACT_ADD_BIAS, 6'd0, 16'sh7FFF, 1'b0));
		send_item(make_item(nmr_pkg::ACT_SAMPLE, 6'd62, 16'sh5555, 1'b1));
		settle();

		for (int seg = 0; seg < 4; seg++) begin
			write_mode(seg % 2 == 0);
			steady = (seg == 2);
			run_random(385);
			settle();
		end
		steady = 1'b0;

		$display("Covered %0d items and %0d results over %0d mode writes,",
			sb.items_seen, sb.results_seen, mode_writes);
		$display("including update clamps, ReLU and identity outputs and stalls on both streams.");
		if (sb.failures == 0 && sb.awaited.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nmr_pkg.sv
rtl/nmr_ram.sv
rtl/neuron_mac_relu.sv
tb/sv/tb.sv
